FILE: hw/rtl/bae_pkg.sv
// shared types and constants for the button autorepeat event block
package bae_pkg;

    localparam int NUM_BUTTONS_DEF = 10;
    localparam int TIME_BITS_DEF   = 32;

    localparam int DELAY_W   = 16;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [DELAY_W-1:0] INITIAL_DELAY_RST = 16'd200;
    localparam logic [DELAY_W-1:0] REPEAT_DELAY_RST  = 16'd100;

    // register index, taken from paddr[2]
    typedef enum logic {
        REG_INITIAL_DELAY = 1'b0,
        REG_REPEAT_DELAY  = 1'b1
    } reg_index_t;

    typedef enum logic [1:0] {
        KIND_PRESS   = 2'd0,
        KIND_REPEAT  = 2'd1,
        KIND_RELEASE = 2'd2
    } event_kind_t;

    // what one lane found for its button in one poll
    typedef struct packed {
        logic        fire;
        event_kind_t kind;
    } lane_evt_t;

    function automatic int idx_width(input int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

endpackage

FILE: hw/rtl/bae_if.sv
// poll and event channel interfaces

interface bae_poll_if #(
    parameter int NUM_BUTTONS = bae_pkg::NUM_BUTTONS_DEF,
    parameter int TIME_BITS   = bae_pkg::TIME_BITS_DEF
);
    logic                   valid;
    logic                   ready;
    logic [NUM_BUTTONS-1:0] pressed_mask;
    logic [TIME_BITS-1:0]   time_now;

    modport source (output valid, output pressed_mask, output time_now, input ready);
    modport sink   (input valid, input pressed_mask, input time_now, output ready);
endinterface

interface bae_event_if #(
    parameter int NUM_BUTTONS = bae_pkg::NUM_BUTTONS_DEF
);
    localparam int IDX_W = bae_pkg::idx_width(NUM_BUTTONS);

    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] button_index;
    logic [1:0]       event_kind;
    logic             last_event;

    modport source (output valid, output button_index, output event_kind,
                    output last_event, input ready);
    modport sink   (input valid, input button_index, input event_kind,
                    input last_event, output ready);
endinterface

FILE: hw/rtl/bae_cfg.sv
// apb register file for the two delay settings
module bae_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [bae_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [bae_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [bae_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready,
    output logic [bae_pkg::DELAY_W-1:0]         initial_delay,
    output logic [bae_pkg::DELAY_W-1:0]         repeat_delay
);

    logic [bae_pkg::DELAY_W-1:0] initial_delay_reg;
    logic [bae_pkg::DELAY_W-1:0] repeat_delay_reg;
    logic                        wr_en;
    bae_pkg::reg_index_t         reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_sel = bae_pkg::reg_index_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            initial_delay_reg <= bae_pkg::INITIAL_DELAY_RST;
            repeat_delay_reg  <= bae_pkg::REPEAT_DELAY_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                bae_pkg::REG_INITIAL_DELAY: initial_delay_reg <= pwdata[bae_pkg::DELAY_W-1:0];
                bae_pkg::REG_REPEAT_DELAY:  repeat_delay_reg  <= pwdata[bae_pkg::DELAY_W-1:0];
                default:                    ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            bae_pkg::REG_INITIAL_DELAY:
                prdata = bae_pkg::APB_DATA_W'(initial_delay_reg);
            bae_pkg::REG_REPEAT_DELAY:
                prdata = bae_pkg::APB_DATA_W'(repeat_delay_reg);
            default:
                prdata = '0;
        endcase
    end

    assign initial_delay = initial_delay_reg;
    assign repeat_delay  = repeat_delay_reg;

endmodule

FILE: hw/rtl/bae_lane.sv
// one button: edge detect, repeat deadline and its wrap-safe compare
module bae_lane #(
    parameter int TIME_BITS = bae_pkg::TIME_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        eval,
    input  logic                        is_down,
    input  logic                        was_down,
    input  logic [TIME_BITS-1:0]        now,
    input  logic [bae_pkg::DELAY_W-1:0] initial_delay,
    input  logic [bae_pkg::DELAY_W-1:0] repeat_delay,
    output bae_pkg::lane_evt_t          result
);

    logic [TIME_BITS-1:0] deadline_reg;
    logic [TIME_BITS-1:0] deadline_next;
    logic [TIME_BITS-1:0] diff;
    logic                 reached;

    // reached when now - deadline reads as non-negative
    assign diff    = now - deadline_reg;
    assign reached = !diff[TIME_BITS-1];

    always_comb
    begin
        result.fire   = 1'b0;
        result.kind   = bae_pkg::KIND_PRESS;
        deadline_next = deadline_reg;
        if (is_down && !was_down)
        begin
            result.fire   = 1'b1;
            result.kind   = bae_pkg::KIND_PRESS;
            deadline_next = now + TIME_BITS'(initial_delay);
        end
        else if (is_down && reached)
        begin
            result.fire   = 1'b1;
            result.kind   = bae_pkg::KIND_REPEAT;
            deadline_next = now + TIME_BITS'(repeat_delay);
        end
        else if (!is_down && was_down)
        begin
            result.fire = 1'b1;
            result.kind = bae_pkg::KIND_RELEASE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deadline_reg <= '0;
        end
        else if (eval)
        begin
            deadline_reg <= deadline_next;
        end
    end

endmodule

FILE: hw/rtl/bae_merge.sv
// collects lane events and sends them out one beat at a time in index order
module bae_merge #(
    parameter int NUM_BUTTONS = bae_pkg::NUM_BUTTONS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   eval,
    input  bae_pkg::lane_evt_t [NUM_BUTTONS-1:0]   lane_res,
    bae_event_if.source                            events,
    output logic                                   idle
);

    localparam int IDX_W = bae_pkg::idx_width(NUM_BUTTONS);

    logic [NUM_BUTTONS-1:0]    pending_reg;
    logic [NUM_BUTTONS-1:0]    pending_next;
    bae_pkg::event_kind_t      kind_reg [NUM_BUTTONS];
    logic [NUM_BUTTONS-1:0]    sel_onehot;
    logic [IDX_W-1:0]          sel_idx;
    logic                      found;
    logic                      load;

    logic                      out_valid_reg;
    logic [IDX_W-1:0]          out_index_reg;
    bae_pkg::event_kind_t      out_kind_reg;
    logic                      out_last_reg;

    // lowest pending button goes next
    always_comb
    begin
        sel_onehot = '0;
        sel_idx    = '0;
        found      = 1'b0;
        for (int i = 0; i < NUM_BUTTONS; i++)
        begin
            if (!found && pending_reg[i])
            begin
                sel_onehot[i] = 1'b1;
                sel_idx       = IDX_W'(i);
                found         = 1'b1;
            end
        end
    end

    assign load = found && (!out_valid_reg || events.ready);

    always_comb
    begin
        pending_next = pending_reg;
        if (eval)
        begin
            for (int i = 0; i < NUM_BUTTONS; i++)
            begin
                pending_next[i] = lane_res[i].fire;
            end
        end
        else if (load)
        begin
            pending_next = pending_reg & ~sel_onehot;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pending_reg <= pending_next;
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (events.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (eval)
        begin
            for (int i = 0; i < NUM_BUTTONS; i++)
            begin
                kind_reg[i] <= lane_res[i].kind;
            end
        end
        if (load)
        begin
            out_index_reg <= sel_idx;
            out_kind_reg  <= kind_reg[sel_idx];
            out_last_reg  <= ((pending_reg & ~sel_onehot) == '0);
        end
    end

    assign events.valid        = out_valid_reg;
    assign events.button_index = out_index_reg;
    assign events.event_kind   = out_kind_reg;
    assign events.last_event   = out_last_reg;
    assign idle                = (pending_reg == '0);

endmodule

FILE: hw/rtl/button_autorepeat_events.sv
// button autorepeat event generator, top level
// poll channel: one beat per poll of the panel, a pressed-button mask and a
// free-running tick count. events channel: one beat per event, in button
// index order, with last_event set on the final beat of a poll; a poll that
// yields no event produces no beat at all.
// registers on the apb port: initial_delay at 0x0, repeat_delay at 0x4.
// each button has its own lane that compares against its repeat deadline;
// all lanes evaluate in the cycle after the poll is taken, then a merge
// stage serializes the events through an output register.
// a taken poll is registered, the lanes evaluate it into the pending events
// of the merge stage, and each event then moves into the output register.
// the merge stage sends one event per cycle while the events channel does
// not stall; the next poll is taken once the last event of the previous poll
// sits in the output register. a stall on the events channel holds that
// register and the pending events; poll ready stays low until those events drain.
// reset clears the previous mask, all deadlines and the pipeline, and loads
// the delays with 200 and 100 ticks.
module button_autorepeat_events #(
    parameter int NUM_BUTTONS = bae_pkg::NUM_BUTTONS_DEF,
    parameter int TIME_BITS   = bae_pkg::TIME_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    bae_poll_if.sink                          poll,
    bae_event_if.source                       events,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [bae_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [bae_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [bae_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);

    logic [bae_pkg::DELAY_W-1:0]          initial_delay;
    logic [bae_pkg::DELAY_W-1:0]          repeat_delay;

    logic                                 eval_reg;
    logic [NUM_BUTTONS-1:0]               mask_reg;
    logic [TIME_BITS-1:0]                 time_reg;
    logic [NUM_BUTTONS-1:0]               prev_mask_reg;
    logic                                 merge_idle;
    logic                                 poll_accept;
    bae_pkg::lane_evt_t [NUM_BUTTONS-1:0] lane_res;

    bae_cfg u_cfg (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .initial_delay (initial_delay),
        .repeat_delay  (repeat_delay)
    );

    assign poll.ready  = !eval_reg && merge_idle;
    assign poll_accept = poll.valid && poll.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eval_reg      <= 1'b0;
            prev_mask_reg <= '0;
        end
        else
        begin
            eval_reg <= poll_accept;
            if (eval_reg)
            begin
                prev_mask_reg <= mask_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (poll_accept)
        begin
            mask_reg <= poll.pressed_mask;
            time_reg <= poll.time_now;
        end
    end

    for (genvar g = 0; g < NUM_BUTTONS; g++)
    begin : g_lane
        bae_lane #(
            .TIME_BITS (TIME_BITS)
        ) u_lane (
            .clk           (clk),
            .rst_n         (rst_n),
            .eval          (eval_reg),
            .is_down       (mask_reg[g]),
            .was_down      (prev_mask_reg[g]),
            .now           (time_reg),
            .initial_delay (initial_delay),
            .repeat_delay  (repeat_delay),
            .result        (lane_res[g])
        );
    end

    bae_merge #(
        .NUM_BUTTONS (NUM_BUTTONS)
    ) u_merge (
        .clk      (clk),
        .rst_n    (rst_n),
        .eval     (eval_reg),
        .lane_res (lane_res),
        .events   (events),
        .idle     (merge_idle)
    );

endmodule

FILE: hw/rtl/bae_checker.sv
// port-level checks for the button autorepeat event block, bound to the top
module bae_checker #(
    parameter int NUM_BUTTONS = bae_pkg::NUM_BUTTONS_DEF
) (
    input logic                                   clk,
    input logic                                   rst_n,
    input logic                                   poll_valid,
    input logic                                   poll_ready,
    input logic                                   ev_valid,
    input logic                                   ev_ready,
    input logic [bae_pkg::idx_width(NUM_BUTTONS)-1:0] ev_index,
    input logic [1:0]                             ev_kind,
    input logic                                   ev_last
);

    // a stalled event beat keeps its contents
    assert property (@(posedge clk) disable iff (!rst_n)
        ev_valid && !ev_ready |=> ev_valid && $stable(ev_index) && $stable(ev_kind)
            && $stable(ev_last))
        else $error("event beat changed while stalled");

    // a poll is evaluated before the next one is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        poll_valid && poll_ready |=> !poll_ready)
        else $error("poll taken while previous poll still in evaluation");

    // events only name real buttons and real kinds
    assert property (@(posedge clk) disable iff (!rst_n)
        ev_valid |-> (ev_index < NUM_BUTTONS)
            && (ev_kind == bae_pkg::KIND_PRESS || ev_kind == bae_pkg::KIND_REPEAT
                || ev_kind == bae_pkg::KIND_RELEASE))
        else $error("event beat with bad index or kind");

endmodule

bind button_autorepeat_events bae_checker #(
    .NUM_BUTTONS (NUM_BUTTONS)
) u_bae_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .poll_valid (poll.valid),
    .poll_ready (poll.ready),
    .ev_valid   (events.valid),
    .ev_ready   (events.ready),
    .ev_index   (events.button_index),
    .ev_kind    (events.event_kind),
    .ev_last    (events.last_event)
);
